### hdl/efe_pkg.sv
package efe_pkg;

   localparam int unsigned RUN_MAX = 7;
   localparam int unsigned CNT_W   = $clog2(RUN_MAX + 1);

   localparam logic [7:0] FRM_START = 8'hAA;
   localparam logic [7:0] FRM_END   = 8'h55;
   localparam logic [7:0] FRM_ESC   = 8'hFD;
   localparam logic [7:0] ESC_START = 8'h02;
   localparam logic [7:0] ESC_END   = 8'h01;
   localparam logic [7:0] ESC_ESC   = 8'h00;

   localparam logic FUNC_HEADER = 1'b0;
   localparam logic FUNC_DATA   = 1'b1;

   typedef logic [RUN_MAX-1:0][7:0] byte_list_type;

   // bytes caused by one input item, in wire order
   typedef struct packed {
      byte_list_type    bytes;
      logic [CNT_W-1:0] count;
      logic             closes;
   } run_type;

   function automatic run_type append_byte(run_type r, logic [7:0] b);
      run_type o;
      o = r;
      o.bytes[r.count[CNT_W-1:0]] = b;
      o.count = r.count + CNT_W'(1);
      return o;
   endfunction

   function automatic run_type append_esc(run_type r, logic [7:0] b);
      run_type o;
      o = r;
      case (b)
         FRM_START: begin
            o = append_byte(o, FRM_ESC);
            o = append_byte(o, ESC_START);
         end
         FRM_END: begin
            o = append_byte(o, FRM_ESC);
            o = append_byte(o, ESC_END);
         end
         FRM_ESC: begin
            o = append_byte(o, FRM_ESC);
            o = append_byte(o, ESC_ESC);
         end
         default: begin
            o = append_byte(o, b);
         end
      endcase
      return o;
   endfunction

endpackage

### hdl/efe_encode.sv
module efe_encode
   import efe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       func,
   input  logic [7:0] cmd_code,
   input  logic [7:0] payload_len,
   input  logic [7:0] data_byte,
   output logic       push,
   output run_type    run
);

   logic [7:0] bcc_acc_ff, bcc_acc_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       in_frame_ff, in_frame_in;

   logic [7:0] bcc_next;
   logic [7:0] left_next;
   logic       close;

   always_comb begin
      run = '0;
      bcc_next = '0;
      left_next = '0;
      close = 1'b0;
      if (func == FUNC_HEADER) begin
         run = append_byte(run, FRM_START);
         run = append_esc(run, cmd_code);
         run = append_esc(run, payload_len);
         bcc_next = cmd_code ^ payload_len;
         left_next = payload_len;
      end else begin
         run = append_esc(run, data_byte);
         bcc_next = bcc_acc_ff ^ data_byte;
         left_next = bytes_left_ff - 8'd1;
      end
      close = (left_next == 8'd0);
      if (close) begin
         run = append_esc(run, bcc_next);
         run = append_byte(run, FRM_END);
         run.closes = 1'b1;
      end
   end

   assign push = accept && ((func == FUNC_HEADER) || in_frame_ff);

   always_comb begin
      bcc_acc_in = bcc_acc_ff;
      bytes_left_in = bytes_left_ff;
      in_frame_in = in_frame_ff;
      if (push) begin
         if (close) begin
            bcc_acc_in = '0;
            bytes_left_in = '0;
            in_frame_in = 1'b0;
         end else begin
            bcc_acc_in = bcc_next;
            bytes_left_in = left_next;
            in_frame_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcc_acc_ff <= '0;
         bytes_left_ff <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         bcc_acc_ff <= bcc_acc_in;
         bytes_left_ff <= bytes_left_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

### hdl/efe_emit.sv
module efe_emit
   import efe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  run_type    run,
   output logic       take_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic             pend_valid_ff, pend_valid_in;
   run_type          pend_ff, pend_in;
   logic             cur_valid_ff, cur_valid_in;
   run_type          cur_ff, cur_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic last;
   logic beat;
   logic cur_free;

   assign last = (idx_ff == cur_ff.count - CNT_W'(1));
   assign beat = cur_valid_ff && rsp_ready;
   assign cur_free = !cur_valid_ff || (beat && last);
   assign take_ready = !pend_valid_ff || cur_free;

   assign rsp_valid = cur_valid_ff;
   assign rsp_out_byte = cur_ff.bytes[idx_ff];
   assign rsp_run_last = last;
   assign rsp_frame_end = last && cur_ff.closes;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      cur_valid_in = cur_valid_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      if (cur_free) begin
         cur_valid_in = pend_valid_ff;
         cur_in = pend_ff;
         idx_in = '0;
      end else if (beat) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (take_ready) begin
         pend_valid_in = push;
         pend_in = run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cur_ff <= cur_in;
   end

`ifndef ASSERT_OFF
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff < cur_ff.count))
      else $error("byte index past end of run");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_ff.count != '0))
      else $error("empty run queued");

   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_out_byte == FRM_END && rsp_run_last))
      else $error("frame end flag on wrong byte");

   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      (beat && !last) |=> (idx_ff == $past(idx_ff) + CNT_W'(1)))
      else $error("byte index did not advance");
`endif

endmodule

### hdl/escaped_frame_encoder_bcc.sv
// escaped frame encoder with xor block check
//
// req channel: one beat per item. req_func low is a header (req_cmd_code,
// req_payload_len), high is a payload byte (req_data_byte). rsp channel: one
// encoded wire byte per beat, with rsp_run_last on the final byte caused by
// an item and rsp_frame_end on the closing 0x55.
//
// an accepted item is encoded into a run of 1 to 7 bytes held in a pending
// register; the run moves to the output register when the previous run has
// been fully taken. with the output free, a run goes from the pending
// register to the output register before its first byte appears. the single
// rsp port sets the rate: an item holds the output until its bytes are taken,
// 1 for a plain payload byte, 2 for an escaped one, up to 7 for a header of
// an empty frame. payload beats while no frame is open are taken and dropped.
//
// reset clears the frame state (checksum, byte count, open flag) and both run
// valid flags. while the receiver stalls, the current byte holds and one more
// item can be taken into the pending register before req_ready drops.
module escaped_frame_encoder_bcc
   import efe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_cmd_code,
   input  logic [7:0] req_payload_len,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic    accept;
   logic    push;
   run_type run;

   assign accept = req_valid && req_ready;

   efe_encode u_encode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .cmd_code    (req_cmd_code),
      .payload_len (req_payload_len),
      .data_byte   (req_data_byte),
      .push        (push),
      .run         (run)
   );

   efe_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .run           (run),
      .take_ready    (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### tb/escaped_frame_encoder_bcc_tb.sv
`timescale 1ns / 1ps

module escaped_frame_encoder_bcc_tb
   import efe_pkg::*;
();

   typedef struct {
      logic       func;
      logic [7:0] cmd;
      logic [7:0] len;
      logic [7:0] data;
   } req_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } wire_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_cmd_code = 8'h00;
   logic [7:0] req_payload_len = 8'h00;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_frame_end;

   req_item_type  item_q[$];
   wire_beat_type wire_exp_q[$];
   wire_beat_type pend_run[$];

   logic [7:0] frame_bcc = 8'h00;
   logic [7:0] frame_left = 8'h00;
   logic       frame_open = 1'b0;

   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 64;
   int unsigned err_count = 0;
   int unsigned items_made = 0;
   logic        gen_open = 1'b0;

   escaped_frame_encoder_bcc dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_cmd_code    (req_cmd_code),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_end   (rsp_frame_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // frame encoding predictor
   function automatic void emit_wire(logic [7:0] b, logic fe);
      wire_beat_type w;
      w.out_byte = b;
      w.run_last = 1'b0;
      w.frame_end = fe;
      pend_run.push_back(w);
   endfunction

   function automatic void emit_escaped(logic [7:0] b);
      case (b)
         FRM_START: begin
            emit_wire(FRM_ESC, 1'b0);
            emit_wire(ESC_START, 1'b0);
         end
         FRM_END: begin
            emit_wire(FRM_ESC, 1'b0);
            emit_wire(ESC_END, 1'b0);
         end
         FRM_ESC: begin
            emit_wire(FRM_ESC, 1'b0);
            emit_wire(ESC_ESC, 1'b0);
         end
         default: begin
            emit_wire(b, 1'b0);
         end
      endcase
   endfunction

   function automatic void emit_close();
      emit_escaped(frame_bcc);
      emit_wire(FRM_END, 1'b1);
      frame_open = 1'b0;
      frame_left = 8'h00;
      frame_bcc = 8'h00;
   endfunction

   function automatic void encode_item(logic func, logic [7:0] cmd, logic [7:0] len,
                                       logic [7:0] data);
      pend_run = {};
      if (func == FUNC_HEADER) begin
         emit_wire(FRM_START, 1'b0);
         emit_escaped(cmd);
         emit_escaped(len);
         frame_bcc = cmd ^ len;
         frame_left = len;
         frame_open = 1'b1;
         if (frame_left == 8'h00) emit_close();
      end else begin
         if (!frame_open) return;
         emit_escaped(data);
         frame_bcc = frame_bcc ^ data;
         frame_left = frame_left - 8'd1;
         if (frame_left == 8'h00) emit_close();
      end
      pend_run[pend_run.size()-1].run_last = 1'b1;
      foreach (pend_run[i]) wire_exp_q.push_back(pend_run[i]);
   endfunction

   // driver
   always @(posedge clock) begin : req_driver
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            encode_item(req_func, req_cmd_code, req_payload_len, req_data_byte);
         if (!req_valid || req_ready) begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = item_q.pop_front();
               req_func <= nxt.func;
               req_cmd_code <= nxt.cmd;
               req_payload_len <= nxt.len;
               req_data_byte <= nxt.data;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      wire_beat_type exp_b;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wire_exp_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual byte %h last %b end %b",
                        $time, rsp_out_byte, rsp_run_last, rsp_frame_end);
               err_count++;
            end else begin
               exp_b = wire_exp_q.pop_front();
               if (rsp_out_byte !== exp_b.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, exp_b.out_byte, rsp_out_byte);
                  err_count++;
               end
               if (rsp_run_last !== exp_b.run_last) begin
                  $display("%0t: run_last expected %b actual %b",
                           $time, exp_b.run_last, rsp_run_last);
                  err_count++;
               end
               if (rsp_frame_end !== exp_b.frame_end) begin
                  $display("%0t: frame_end expected %b actual %b",
                           $time, exp_b.frame_end, rsp_frame_end);
                  err_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stimulus helpers
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(11))
         0: return FRM_START;
         1: return FRM_END;
         2: return FRM_ESC;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void add_header(logic [7:0] cmd, logic [7:0] len);
      req_item_type it;
      it.func = FUNC_HEADER;
      it.cmd = cmd;
      it.len = len;
      it.data = 8'($urandom_range(255));
      item_q.push_back(it);
      items_made++;
   endfunction

   function automatic void add_payload(logic [7:0] data);
      req_item_type it;
      it.func = FUNC_DATA;
      it.cmd = 8'($urandom_range(255));
      it.len = 8'($urandom_range(255));
      it.data = data;
      item_q.push_back(it);
      items_made++;
   endfunction

   function automatic void add_frame(logic [7:0] cmd, logic [7:0] len);
      add_header(cmd, len);
      for (int i = 0; i < len; i++) add_payload(pick_byte());
   endfunction

   task automatic random_frames(int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned n;
      logic [7:0]  len;
      stop_at = items_made + budget;
      while (items_made < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // stray beat, dropped when no frame is open
            if (!gen_open) begin
               add_payload(8'($urandom_range(255)));
            end
         end else if (pick < 20) begin
            len = pick_byte();
            if (len == 8'h00) len = 8'h01;
            add_header(pick_byte(), len);
            n = $urandom_range((len > 4) ? 4 : len - 1);
            for (int i = 0; i < n; i++) add_payload(pick_byte());
            gen_open = 1'b1;
         end else begin
            len = (pick < 30) ? 8'($urandom_range(20)) : 8'($urandom_range(8));
            add_frame(pick_byte(), len);
            gen_open = 1'b0;
         end
      end
   endtask

   task automatic drain();
      while (item_q.size() != 0 || req_valid || wire_exp_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_frame(8'h00, 8'h00);
      add_frame(8'hFF, 8'h00);
      add_frame(FRM_START, 8'h00);
      add_frame(FRM_END, 8'h00);
      add_frame(FRM_ESC, 8'h00);
      add_payload(8'hFF);
      add_payload(8'h00);
      add_header(8'hFF, 8'h03);
      add_payload(FRM_START);
      add_payload(FRM_END);
      add_payload(FRM_ESC);
      add_header(8'h5A, 8'h05);
      add_payload(8'h00);
      add_payload(8'hFF);
      add_header(8'h01, 8'h01);
      add_payload(8'h7E);
      add_header(8'hC3, 8'hFF);
      add_header(8'h3C, 8'h02);
      add_payload(8'h80);
      add_payload(8'h01);
      add_payload(8'hA5);
      random_frames(45);
      drain();

      send_idle_pct = 64;
      recv_idle_pct = 19;
      random_frames(45);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_frame(pick_byte(), 8'hFF);
      gen_open = 1'b0;
      random_frames(40);
      drain();

      repeat (30) @(posedge clock);
      if (err_count == 0) begin
         $display("escaped_frame_encoder_bcc verification clean");
      end else begin
         $display("escaped_frame_encoder_bcc verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("escaped_frame_encoder_bcc verification failed");
      $finish;
   end

endmodule
